>>> hw/rtl/tmse_pkg.sv
// Shared types, codes and helpers of the Turing machine step engine.
package tmse_pkg;

    // Action codes carried in the input beat's tuser.
    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_STEP  = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_START = 3'd4;

    // Tape symbols; the spare code is stored as blank.
    localparam logic [1:0] SYM_BLANK   = 2'd0;
    localparam logic [1:0] SYM_INVALID = 2'd3;

    // Head motion codes; anything other than left or right stays.
    localparam logic [1:0] MOVE_LEFT  = 2'd0;
    localparam logic [1:0] MOVE_RIGHT = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_EDGE    = 2'd2;
    localparam logic [1:0] ST_HALTED  = 2'd3;

    // Configuration register indexes (byte address bit 2).
    localparam logic CFG_START_STATE = 1'b0;
    localparam logic CFG_START_POS   = 1'b1;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  rule_slot;
        logic        rule_valid;
        logic [7:0]  rule_state;
        logic [1:0]  rule_symbol;
        logic [7:0]  rule_next_state;
        logic [1:0]  rule_write_symbol;
        logic [1:0]  rule_move;
        logic [11:0] cell_address;
        logic [1:0]  cell_symbol;
    } t_item;

    typedef struct packed {
        logic [7:0] match_state;
        logic [1:0] match_symbol;
        logic [7:0] next_state;
        logic [1:0] write_symbol;
        logic [1:0] move;
    } t_rule;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  machine_state;
        logic [11:0] head_position;
        logic [1:0]  read_symbol;
        logic [5:0]  rule_hit;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic item_ld;
        logic rule_wr;
        logic cell_wr;
        logic cell_rd;
        logic rd_cap;
        logic head_rd;
        logic hd_cap;
        logic start;
        logic srch_init;
        logic srch_step;
        logic nomatch;
        logic apply;
        logic res_ld;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] action;
        logic       halted;
        logic       clr_last;
        logic       hit;
        logic       last;
    } t_dp_stat;

    function automatic logic [1:0] norm_symbol(input logic [1:0] s);
        return (s == SYM_INVALID) ? SYM_BLANK : s;
    endfunction

endpackage

>>> hw/rtl/turing_machine_step_engine.sv
// Top level of the Turing machine step engine: stream ports, configuration port, assertions.
// Each beat is taken in idle and decoded; a rule load, cell write, start or unused action then
// finishes, a cell read first waits for the tape data, and a step reads the head cell and,
// unless halted, scans the rules from slot 0 upward; this sequential scan sets the step time.
// One item at a time: the input is ready again in the cycle after the result is loaded.
// Reset (synchronous, active low) clears the rule valid bits and then sweeps the tape to blank,
// one cell a cycle over all TAPE_DEPTH cells, before the first input beat is taken.
module turing_machine_step_engine #(
    parameter int TAPE_DEPTH = 4096,
    parameter int RULE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, lowest bit up: rule_slot[5:0], rule_valid[6], rule_state[14:7],
    // rule_symbol[16:15], rule_next_state[24:17], rule_write_symbol[26:25],
    // rule_move[28:27], cell_address[40:29], cell_symbol[42:41], zero fill[47:43].
    input  logic [47:0] s_axis_tdata,
    // tuser: action[2:0].
    input  logic [2:0]  s_axis_tuser,

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, lowest bit up: status[1:0], machine_state[9:2], head_position[21:10],
    // read_symbol[23:22], rule_hit[29:24], zero fill[31:30].
    output logic [31:0] m_axis_tdata,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]          r_start_state;
    logic [11:0]         r_start_pos;
    tmse_pkg::t_item     item;
    tmse_pkg::t_dp_cmd   cmd;
    tmse_pkg::t_dp_stat  stat;
    tmse_pkg::t_result   result;
    logic                cfg_wr;

    // The port never stalls; a register is written on the access cycle of a write.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_start_pos   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                tmse_pkg::CFG_START_STATE: r_start_state <= pwdata[7:0];
                tmse_pkg::CFG_START_POS:   r_start_pos   <= pwdata[11:0];
                default:                   r_start_state <= r_start_state;
            endcase
        end
    end

    assign prdata = (paddr[2] == tmse_pkg::CFG_START_POS) ? {20'd0, r_start_pos}
                                                          : {24'd0, r_start_state};

    // Unpack the input beat into the item fields.
    assign item = '{
        action:            s_axis_tuser,
        rule_slot:         s_axis_tdata[5:0],
        rule_valid:        s_axis_tdata[6],
        rule_state:        s_axis_tdata[14:7],
        rule_symbol:       s_axis_tdata[16:15],
        rule_next_state:   s_axis_tdata[24:17],
        rule_write_symbol: s_axis_tdata[26:25],
        rule_move:         s_axis_tdata[28:27],
        cell_address:      s_axis_tdata[40:29],
        cell_symbol:       s_axis_tdata[42:41]
    };

    // The controller sequences each item; the datapath owns the tape, the rules and the
    // machine registers, plus the result register that decouples the output stream.
    tmse_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid)
    );

    tmse_dp #(
        .TAPE_DEPTH (TAPE_DEPTH),
        .RULE_DEPTH (RULE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (item),
        .i_cfg_start_state (r_start_state),
        .i_cfg_start_pos   (r_start_pos),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_result          (result)
    );

    assign m_axis_tdata = {2'b00, result.rule_hit, result.read_symbol, result.head_position,
                           result.machine_state, result.status};

`ifndef SYNTHESIS
    // Only one item is in flight: right after a beat is taken the input side closes.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    // A fired rule slot is only reported with an ok or tape-edge status.
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[29:24] != 6'd0) |->
            (m_axis_tdata[1:0] == tmse_pkg::ST_OK) || (m_axis_tdata[1:0] == tmse_pkg::ST_EDGE))
        else $error("rule slot reported without a firing step");

    // The head never leaves the tape.
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[21:10]) < 32'(TAPE_DEPTH)))
        else $error("head position beyond the tape");
`endif

endmodule

>>> hw/rtl/tmse_ctrl.sv
// Controller state machine of the Turing machine step engine.
module tmse_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    input  logic                i_m_ready,
    input  tmse_pkg::t_dp_stat  i_stat,
    output tmse_pkg::t_dp_cmd   o_cmd,
    output logic                o_s_ready,
    output logic                o_m_valid
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_HD_WAIT,
        S_SEARCH,
        S_APPLY,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.item_ld = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.action)
                    tmse_pkg::ACT_LOAD: begin
                        o_cmd.rule_wr = 1'b1;
                        n_state       = S_FINISH;
                    end
                    tmse_pkg::ACT_WRITE: begin
                        o_cmd.cell_wr = 1'b1;
                        n_state       = S_FINISH;
                    end
                    tmse_pkg::ACT_READ: begin
                        o_cmd.cell_rd = 1'b1;
                        n_state       = S_RD_WAIT;
                    end
                    tmse_pkg::ACT_START: begin
                        o_cmd.start = 1'b1;
                        n_state     = S_FINISH;
                    end
                    tmse_pkg::ACT_STEP: begin
                        o_cmd.head_rd = 1'b1;
                        n_state       = S_HD_WAIT;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_RD_WAIT: begin
                o_cmd.rd_cap = 1'b1;
                n_state      = S_FINISH;
            end
            S_HD_WAIT: begin
                o_cmd.hd_cap = 1'b1;
                if (i_stat.halted) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_state         = S_SEARCH;
                end
            end
            S_SEARCH: begin
                priority if (i_stat.hit) begin
                    n_state = S_APPLY;
                end else if (i_stat.last) begin
                    o_cmd.nomatch = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.srch_step = 1'b1;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.res_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

endmodule

>>> hw/rtl/tmse_dp.sv
// Datapath of the Turing machine step engine: tape and rule memories, machine registers.
module tmse_dp #(
    parameter int TAPE_DEPTH = 4096,
    parameter int RULE_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tmse_pkg::t_item     i_item,
    input  logic [7:0]          i_cfg_start_state,
    input  logic [11:0]         i_cfg_start_pos,
    input  tmse_pkg::t_dp_cmd   i_cmd,
    output tmse_pkg::t_dp_stat  o_stat,
    output tmse_pkg::t_result   o_result
);

    localparam int HW  = $clog2(TAPE_DEPTH);
    localparam int RIW = $clog2(RULE_DEPTH);

    // Memories.
    logic [1:0]       r_tape_mem [TAPE_DEPTH];
    tmse_pkg::t_rule  r_rule_mem [RULE_DEPTH];
    logic [1:0]       r_tape_q;
    tmse_pkg::t_rule  r_rule_q;
    logic             r_rule_vq;
    logic [RULE_DEPTH-1:0] r_rule_vld;

    // Control registers.
    logic             r_halted;
    logic [7:0]       r_cur_state;
    logic [HW-1:0]    r_head;
    logic [HW-1:0]    r_clr_addr;
    logic [RIW-1:0]   r_srch_idx;
    logic [RIW-1:0]   r_cmp_idx;
    logic             r_cmp_live;

    // Per-item payload registers.
    tmse_pkg::t_item   r_item;
    logic [1:0]        r_rsym;
    logic [5:0]        r_hit;
    logic [1:0]        r_step_status;
    logic              r_is_step;
    tmse_pkg::t_result r_result;

    logic              cell_ok;
    logic              slot_ok;
    logic              head_last;
    logic              at_edge;
    logic              tape_we;
    logic [HW-1:0]     tape_wa;
    logic [1:0]        tape_wd;
    logic              tape_re;
    logic [HW-1:0]     tape_ra;
    logic [HW-1:0]     start_head;
    logic [RIW-1:0]    slot_idx;

    assign cell_ok   = 32'(r_item.cell_address) < 32'(TAPE_DEPTH);
    assign slot_ok   = 32'(r_item.rule_slot) < 32'(RULE_DEPTH);
    assign slot_idx  = RIW'(r_item.rule_slot);
    assign head_last = (32'(r_head) + 32'd1) >= 32'(TAPE_DEPTH);
    assign start_head = (32'(i_cfg_start_pos) < 32'(TAPE_DEPTH)) ? HW'(i_cfg_start_pos)
                                                                : HW'(TAPE_DEPTH - 1);
    assign at_edge = ((r_rule_q.move == tmse_pkg::MOVE_LEFT) && (r_head == '0)) ||
                     ((r_rule_q.move == tmse_pkg::MOVE_RIGHT) && head_last);

    // Single tape write port shared by the clearing sweep, cell writes and step writes.
    always_comb begin
        tape_we = 1'b0;
        tape_wa = r_head;
        tape_wd = tmse_pkg::SYM_BLANK;
        if (i_cmd.clr_wr) begin
            tape_we = 1'b1;
            tape_wa = r_clr_addr;
        end else if (i_cmd.cell_wr && cell_ok) begin
            tape_we = 1'b1;
            tape_wa = HW'(r_item.cell_address);
            tape_wd = tmse_pkg::norm_symbol(r_item.cell_symbol);
        end else if (i_cmd.apply) begin
            tape_we = 1'b1;
            tape_wd = r_rule_q.write_symbol;
        end
    end

    assign tape_re = i_cmd.cell_rd || i_cmd.head_rd;
    assign tape_ra = i_cmd.cell_rd ? HW'(r_item.cell_address) : r_head;

    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_tape_mem[tape_wa] <= tape_wd;
        end
        if (tape_re) begin
            r_tape_q <= r_tape_mem[tape_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rule_wr && slot_ok) begin
            r_rule_mem[slot_idx] <= '{
                match_state:  r_item.rule_state,
                match_symbol: r_item.rule_symbol,
                next_state:   r_item.rule_next_state,
                write_symbol: tmse_pkg::norm_symbol(r_item.rule_write_symbol),
                move:         r_item.rule_move
            };
        end
        if (i_cmd.srch_step) begin
            r_rule_q  <= r_rule_mem[r_srch_idx];
            r_rule_vq <= r_rule_vld[r_srch_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_vld <= '0;
        end else if (i_cmd.rule_wr && slot_ok) begin
            r_rule_vld[slot_idx] <= r_item.rule_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted    <= 1'b1;
            r_cur_state <= '0;
            r_head      <= '0;
            r_clr_addr  <= '0;
            r_srch_idx  <= '0;
            r_cmp_idx   <= '0;
            r_cmp_live  <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.start) begin
                r_cur_state <= i_cfg_start_state;
                r_head      <= start_head;
                r_halted    <= 1'b0;
            end
            if (i_cmd.srch_init) begin
                r_srch_idx <= '0;
                r_cmp_live <= 1'b0;
            end
            if (i_cmd.srch_step) begin
                r_cmp_idx  <= r_srch_idx;
                r_srch_idx <= r_srch_idx + 1'b1;
                r_cmp_live <= 1'b1;
            end
            if (i_cmd.nomatch) begin
                r_halted <= 1'b1;
            end
            if (i_cmd.apply) begin
                r_cur_state <= r_rule_q.next_state;
                if (at_edge) begin
                    r_halted <= 1'b1;
                end else if (r_rule_q.move == tmse_pkg::MOVE_LEFT) begin
                    r_head <= r_head - 1'b1;
                end else if (r_rule_q.move == tmse_pkg::MOVE_RIGHT) begin
                    r_head <= r_head + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_ld) begin
            r_item        <= i_item;
            r_rsym        <= tmse_pkg::SYM_BLANK;
            r_hit         <= '0;
            r_is_step     <= 1'b0;
            r_step_status <= tmse_pkg::ST_OK;
        end
        if (i_cmd.rd_cap) begin
            r_rsym <= cell_ok ? r_tape_q : tmse_pkg::SYM_BLANK;
        end
        if (i_cmd.hd_cap) begin
            r_rsym    <= r_tape_q;
            r_is_step <= 1'b1;
            if (r_halted) begin
                r_step_status <= tmse_pkg::ST_HALTED;
            end
        end
        if (i_cmd.nomatch) begin
            r_step_status <= tmse_pkg::ST_NOMATCH;
        end
        if (i_cmd.apply) begin
            r_hit <= 6'(r_cmp_idx);
            if (at_edge) begin
                r_step_status <= tmse_pkg::ST_EDGE;
            end
        end
        if (i_cmd.res_ld) begin
            r_result <= '{
                status:        r_is_step ? r_step_status
                                         : (r_halted ? tmse_pkg::ST_HALTED : tmse_pkg::ST_OK),
                machine_state: r_cur_state,
                head_position: 12'(r_head),
                read_symbol:   r_rsym,
                rule_hit:      r_hit
            };
        end
    end

    assign o_stat.action   = r_item.action;
    assign o_stat.halted   = r_halted;
    assign o_stat.clr_last = (r_clr_addr == HW'(TAPE_DEPTH - 1));
    assign o_stat.hit      = r_cmp_live && r_rule_vq &&
                             (r_rule_q.match_state == r_cur_state) &&
                             (r_rule_q.match_symbol == r_rsym);
    assign o_stat.last     = r_cmp_live && (r_cmp_idx == RIW'(RULE_DEPTH - 1));
    assign o_result        = r_result;

endmodule

>>> verif/turing_machine_step_engine_test.sv
// Self-checking stream testbench for the Turing machine step engine.
`timescale 1ns / 100ps

module turing_machine_step_engine_test;

    localparam int TAPE_DEPTH = 4096;
    localparam int RULE_DEPTH = 64;

    // Symbol, move and action codes that the package leaves unnamed.
    localparam logic [1:0] SYM_ZERO  = 2'd1;
    localparam logic [1:0] SYM_ONE   = 2'd2;
    localparam logic [1:0] MOVE_STAY = 2'd1;
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;
    localparam logic [11:0] TAPE_LAST = 12'(TAPE_DEPTH - 1);

    // Stimulus stops once this many random beats have been queued.
    localparam int RANDOM_TARGET = 700;
    localparam int PHASE_BUDGET  = 90;
    // Long receiver hold-off that backs the engine up into its input.
    localparam int SQUEEZE_CYCLES = 400;
    // Settling time once everything has drained.
    localparam int DRAIN_CYCLES = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata, lowest bit up: rule_slot, rule_valid, rule_state, rule_symbol,
    // rule_next_state, rule_write_symbol, rule_move, cell_address, cell_symbol, zero fill.
    logic [47:0] s_axis_tdata = '0;
    // tuser: action.
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata, lowest bit up: status, machine_state, head_position, read_symbol, rule_hit.
    logic [31:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    turing_machine_step_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the machine. It is advanced once per accepted input
    // beat, in acceptance order, so it always mirrors what the engine has
    // been asked to do so far.
    // ------------------------------------------------------------------
    tmse_pkg::t_rule rule_image [RULE_DEPTH];
    logic        rule_live  [RULE_DEPTH];
    logic [1:0]  tape_image [TAPE_DEPTH];
    logic [7:0]  machine_code;
    logic [11:0] head_cell;
    logic        machine_halted;
    logic [7:0]  cfg_start_state;
    logic [11:0] cfg_start_pos;

    tmse_pkg::t_item   queued_actions[$];    // beats waiting for the driver
    tmse_pkg::t_result predicted_results[$]; // one entry per accepted beat, oldest first
    tmse_pkg::t_item   on_bus;               // beat currently offered to the engine

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  random_total = 0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    int  hold_left = 0;
    int  holds_done = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    logic [7:0] phase_states [4];

    // The spare symbol code is stored on the tape as blank.
    function automatic logic [1:0] stored_symbol(input logic [1:0] s);
        return (s == tmse_pkg::SYM_INVALID) ? tmse_pkg::SYM_BLANK : s;
    endfunction

    // Appends one beat to the driver's queue.
    function automatic void queue_beat(input tmse_pkg::t_item it);
        queued_actions.insert(queued_actions.size(), it);
    endfunction

    // Applies one action to the shadow machine and returns the result beat it must produce.
    function automatic tmse_pkg::t_result advance_machine(input tmse_pkg::t_item it);
        tmse_pkg::t_result r;
        logic [1:0] under;
        int fired;
        r = '0;
        case (it.action)
            tmse_pkg::ACT_LOAD: begin
                rule_live[it.rule_slot] = it.rule_valid;
                rule_image[it.rule_slot] = '{match_state: it.rule_state,
                                             match_symbol: it.rule_symbol,
                                             next_state: it.rule_next_state,
                                             write_symbol: stored_symbol(it.rule_write_symbol),
                                             move: it.rule_move};
            end
            tmse_pkg::ACT_WRITE: tape_image[it.cell_address] = stored_symbol(it.cell_symbol);
            tmse_pkg::ACT_READ:  r.read_symbol = tape_image[it.cell_address];
            tmse_pkg::ACT_START: begin
                machine_code = cfg_start_state;
                head_cell = cfg_start_pos;
                machine_halted = 1'b0;
            end
            tmse_pkg::ACT_STEP: begin
                under = tape_image[head_cell];
                r.read_symbol = under;
                if (machine_halted) begin
                    r.status = tmse_pkg::ST_HALTED;
                end else begin
                    // The lowest live slot whose state and symbol both match wins.
                    fired = -1;
                    for (int k = 0; k < RULE_DEPTH; k++) begin
                        if (fired < 0 && rule_live[k] && rule_image[k].match_state == machine_code
                                && rule_image[k].match_symbol == under)
                            fired = k;
                    end
                    if (fired < 0) begin
                        machine_halted = 1'b1;
                        r.status = tmse_pkg::ST_NOMATCH;
                    end else begin
                        r.rule_hit = fired[5:0];
                        tape_image[head_cell] = rule_image[fired].write_symbol;
                        machine_code = rule_image[fired].next_state;
                        // Running off either end leaves the head on the end cell and halts.
                        if (rule_image[fired].move == tmse_pkg::MOVE_LEFT) begin
                            if (head_cell == '0) begin
                                machine_halted = 1'b1;
                                r.status = tmse_pkg::ST_EDGE;
                            end else begin
                                head_cell = head_cell - 1'b1;
                            end
                        end else if (rule_image[fired].move == tmse_pkg::MOVE_RIGHT) begin
                            if (head_cell == TAPE_LAST) begin
                                machine_halted = 1'b1;
                                r.status = tmse_pkg::ST_EDGE;
                            end else begin
                                head_cell = head_cell + 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (it.action != tmse_pkg::ACT_STEP)
            r.status = machine_halted ? tmse_pkg::ST_HALTED : tmse_pkg::ST_OK;
        r.machine_state = machine_code;
        r.head_position = head_cell;
        return r;
    endfunction

    function automatic tmse_pkg::t_item load_item(input logic [5:0] slot, input logic valid,
                                                  input logic [7:0] st, input logic [1:0] sym,
                                                  input logic [7:0] nxt,
                                                  input logic [1:0] wsym,
                                                  input logic [1:0] mv);
        tmse_pkg::t_item it;
        it = '0;
        it.action = tmse_pkg::ACT_LOAD;
        it.rule_slot = slot;
        it.rule_valid = valid;
        it.rule_state = st;
        it.rule_symbol = sym;
        it.rule_next_state = nxt;
        it.rule_write_symbol = wsym;
        it.rule_move = mv;
        return it;
    endfunction

    function automatic tmse_pkg::t_item tape_item(input logic [2:0] act,
                                                  input logic [11:0] addr,
                                                  input logic [1:0] sym);
        tmse_pkg::t_item it;
        it = '0;
        it.action = act;
        it.cell_address = addr;
        it.cell_symbol = sym;
        return it;
    endfunction

    function automatic tmse_pkg::t_item bare_item(input logic [2:0] act);
        tmse_pkg::t_item it;
        it = '0;
        it.action = act;
        return it;
    endfunction

    // A rule that keeps the machine inside the phase's small set of states, so
    // that long runs of steps keep finding matches.
    function automatic tmse_pkg::t_item phase_rule(input logic [7:0] st, input logic [1:0] sym);
        int pick;
        logic [1:0] mv;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            mv = tmse_pkg::MOVE_LEFT;
        else if (pick < 8)
            mv = tmse_pkg::MOVE_RIGHT;
        else if (pick == 8)
            mv = MOVE_STAY;
        else
            mv = 2'd3;
        return load_item(6'($urandom_range(0, RULE_DEPTH - 1)), 1'b1, st, sym,
                         phase_states[$urandom_range(0, 3)], 2'($urandom_range(0, 3)), mv);
    endfunction

    // Per-beat wait of either side; a calm phase never idles.
    function automatic int draw_gap(input bit calm);
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers queued beats, predicts each one the moment it is
    // accepted, and idles a drawn number of cycles between beats.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : feed_input
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                predicted_results.insert(predicted_results.size(), advance_machine(on_bus));
            if (tx_wait > 0) begin
                tx_wait <= tx_wait - 1;
                s_axis_tvalid <= 1'b0;
            end else if (queued_actions.size() != 0) begin
                on_bus = queued_actions.pop_front();
                s_axis_tdata <= {5'b0, on_bus.cell_symbol, on_bus.cell_address,
                                 on_bus.rule_move, on_bus.rule_write_symbol,
                                 on_bus.rule_next_state, on_bus.rule_symbol,
                                 on_bus.rule_state, on_bus.rule_valid, on_bus.rule_slot};
                s_axis_tuser <= on_bus.action;
                s_axis_tvalid <= 1'b1;
                tx_wait <= draw_gap(tx_calm);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every accepted result beat is compared field by field
    // with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        tmse_pkg::t_result got;
        tmse_pkg::t_result want;
        int rx_next;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            rx_next = (rx_wait > 0) ? rx_wait - 1 : 0;
            if (m_axis_tvalid && m_axis_tready) begin
                got.status        = m_axis_tdata[1:0];
                got.machine_state = m_axis_tdata[9:2];
                got.head_position = m_axis_tdata[21:10];
                got.read_symbol   = m_axis_tdata[23:22];
                got.rule_hit      = m_axis_tdata[29:24];
                if (predicted_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with nothing pending",
                                              results_seen));
                end else begin
                    want = predicted_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("beat %0d status got %0d want %0d",
                                                  results_seen, got.status, want.status));
                    if (got.machine_state !== want.machine_state)
                        report_mismatch($sformatf("beat %0d machine_state got %0d want %0d",
                                                  results_seen, got.machine_state,
                                                  want.machine_state));
                    if (got.head_position !== want.head_position)
                        report_mismatch($sformatf("beat %0d head_position got %0d want %0d",
                                                  results_seen, got.head_position,
                                                  want.head_position));
                    if (got.read_symbol !== want.read_symbol)
                        report_mismatch($sformatf("beat %0d read_symbol got %0d want %0d",
                                                  results_seen, got.read_symbol,
                                                  want.read_symbol));
                    if (got.rule_hit !== want.rule_hit)
                        report_mismatch($sformatf("beat %0d rule_hit got %0d want %0d",
                                                  results_seen, got.rule_hit, want.rule_hit));
                end
                results_seen <= results_seen + 1;
                rx_next = draw_gap(rx_calm);
            end
            rx_wait <= rx_next;
            m_axis_tready <= (rx_next == 0) && (hold_left == 0);
        end
    end

    // Twice in the run the receiver stops taking results for a long stretch
    // while the sender is offering, so the engine fills and stalls its input.
    always @(posedge i_clk) begin : squeeze_output
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (s_axis_tvalid && ((holds_done == 0 && results_seen >= 60)
                                       || (holds_done == 1 && results_seen >= 450))) begin
            hold_left <= SQUEEZE_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Returns once every queued beat has been taken and every result has come back.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (queued_actions.size() != 0 || s_axis_tvalid || predicted_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes one register through a setup and an access cycle, then reads it back.
    task automatic program_register(input logic idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] readback;
        mask = (idx == tmse_pkg::CFG_START_STATE) ? 32'h0000_00FF : 32'h0000_0FFF;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        // Bits above the register carry noise; the register keeps only its own width.
        pwdata <= (value & mask) | ($urandom & ~mask);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == tmse_pkg::CFG_START_STATE)
            cfg_start_state = value[7:0];
        else
            cfg_start_pos = value[11:0];
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if ((readback & mask) !== (value & mask))
            report_mismatch($sformatf("register %0d reads %0h want %0h",
                                      idx, readback & mask, value & mask));
        @(negedge i_clk);
    endtask

    // One random phase: a small machine over four states, a seeded tape
    // around the start cell, a start, then mostly steps with reads, writes,
    // restarts, rule reloads and fully random beats mixed in.
    task automatic queue_program_phase(input int budget);
        int n;
        int pick;
        logic [1:0] sym;
        logic [63:0] raw;
        tmse_pkg::t_item it;
        n = 0;
        phase_states[0] = cfg_start_state;
        for (int s = 1; s < 4; s++)
            phase_states[s] = 8'($urandom_range(0, 255));
        repeat ($urandom_range(0, 3)) begin
            queue_beat(load_item(6'($urandom_range(0, RULE_DEPTH - 1)), 1'b0,
                                 8'($urandom), 2'($urandom), 8'($urandom),
                                 2'($urandom), 2'($urandom)));
            n++;
        end
        for (int s = 0; s < 4; s++) begin
            for (int k = 0; k < 3; k++) begin
                if ($urandom_range(0, 99) < 85) begin
                    // Now and then the spare symbol, which can never match.
                    sym = ($urandom_range(0, 19) == 0) ? tmse_pkg::SYM_INVALID : 2'(k);
                    queue_beat(phase_rule(phase_states[s], sym));
                    n++;
                end
            end
        end
        repeat (6) begin
            queue_beat(tape_item(tmse_pkg::ACT_WRITE,
                                 cfg_start_pos + 12'($urandom_range(0, 16)) - 12'd8,
                                 2'($urandom_range(0, 3))));
            n++;
        end
        queue_beat(bare_item(tmse_pkg::ACT_START));
        n++;
        while (n < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                it = bare_item(tmse_pkg::ACT_STEP);
            end else if (pick < 70) begin
                it = bare_item(tmse_pkg::ACT_START);
            end else if (pick < 78) begin
                it = tape_item(tmse_pkg::ACT_READ,
                               cfg_start_pos + 12'($urandom_range(0, 40)) - 12'd20,
                               2'($urandom));
            end else if (pick < 84) begin
                it = tape_item(tmse_pkg::ACT_WRITE,
                               cfg_start_pos + 12'($urandom_range(0, 40)) - 12'd20,
                               2'($urandom_range(0, 3)));
            end else if (pick < 90) begin
                it = phase_rule(phase_states[$urandom_range(0, 3)], 2'($urandom_range(0, 2)));
            end else begin
                // Any action code, including the unused ones, with every field random.
                raw = {$urandom, $urandom};
                it = raw[$bits(tmse_pkg::t_item)-1:0];
            end
            queue_beat(it);
            n++;
        end
        random_total += n;
    endtask

    initial begin : run_test
        int phase;
        logic [7:0]  st;
        logic [11:0] pos;
        for (int k = 0; k < RULE_DEPTH; k++) begin
            rule_image[k] = '0;
            rule_live[k] = 1'b0;
        end
        for (int k = 0; k < TAPE_DEPTH; k++)
            tape_image[k] = tmse_pkg::SYM_BLANK;
        machine_code = '0;
        head_cell = '0;
        machine_halted = 1'b1;
        cfg_start_state = '0;
        cfg_start_pos = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. After reset the machine is halted, so the first step
        // must report that; the spare action codes must change nothing.
        program_register(tmse_pkg::CFG_START_STATE, 32'h0000_00A5);
        program_register(tmse_pkg::CFG_START_POS, 32'h0);
        queue_beat(bare_item(tmse_pkg::ACT_STEP));
        queue_beat(bare_item(ACT_SPARE_A));
        queue_beat(bare_item(ACT_SPARE_B));
        queue_beat(bare_item(ACT_SPARE_C));
        queue_beat(tape_item(tmse_pkg::ACT_WRITE, 12'd0, SYM_ZERO));
        queue_beat(tape_item(tmse_pkg::ACT_WRITE, TAPE_LAST, SYM_ONE));
        // The spare symbol written to the tape must read back as blank.
        queue_beat(tape_item(tmse_pkg::ACT_WRITE, 12'd1, tmse_pkg::SYM_INVALID));
        queue_beat(tape_item(tmse_pkg::ACT_READ, 12'd1, tmse_pkg::SYM_BLANK));
        queue_beat(tape_item(tmse_pkg::ACT_READ, TAPE_LAST, tmse_pkg::SYM_BLANK));
        queue_beat(tape_item(tmse_pkg::ACT_READ, 12'd0, tmse_pkg::SYM_BLANK));
        // Slot 0 is cleared, so the matching rule in the top slot must fire
        // instead; that rule writes the spare symbol and uses the spare move code.
        queue_beat(load_item(6'd0, 1'b0, 8'hA5, SYM_ZERO, 8'h11, SYM_ONE,
                             tmse_pkg::MOVE_RIGHT));
        queue_beat(load_item(6'd63, 1'b1, 8'hA5, SYM_ZERO, 8'hFF, tmse_pkg::SYM_INVALID,
                             2'd3));
        queue_beat(load_item(6'd10, 1'b1, 8'hFF, tmse_pkg::SYM_BLANK, 8'h00, SYM_ONE,
                             tmse_pkg::MOVE_LEFT));
        queue_beat(load_item(6'd1, 1'b1, 8'h00, tmse_pkg::SYM_INVALID, 8'h33, SYM_ZERO,
                             tmse_pkg::MOVE_LEFT));
        queue_beat(bare_item(tmse_pkg::ACT_START));
        queue_beat(bare_item(tmse_pkg::ACT_STEP));
        // Moving left from cell 0 runs off the tape.
        queue_beat(bare_item(tmse_pkg::ACT_STEP));
        queue_beat(bare_item(tmse_pkg::ACT_STEP));
        queue_beat(tape_item(tmse_pkg::ACT_READ, 12'd0, tmse_pkg::SYM_BLANK));
        // Restart; no rule matches the cell now under the head.
        queue_beat(bare_item(tmse_pkg::ACT_START));
        queue_beat(bare_item(tmse_pkg::ACT_STEP));
        queue_beat(load_item(6'd2, 1'b1, 8'h00, SYM_ONE, 8'h7F, tmse_pkg::SYM_BLANK,
                             tmse_pkg::MOVE_RIGHT));
        wait_drained();

        // Starting on the last cell, a right move runs off the far end.
        program_register(tmse_pkg::CFG_START_STATE, 32'h0);
        program_register(tmse_pkg::CFG_START_POS, 32'(TAPE_LAST));
        queue_beat(bare_item(tmse_pkg::ACT_START));
        queue_beat(bare_item(tmse_pkg::ACT_STEP));
        queue_beat(tape_item(tmse_pkg::ACT_READ, TAPE_LAST, tmse_pkg::SYM_BLANK));
        wait_drained();

        // Random phases, each with its own start settings, extremes among them.
        phase = 0;
        while (random_total < RANDOM_TARGET) begin
            case (phase % 5)
                0: begin
                    st = 8'hFF;
                    pos = 12'd0;
                end
                1: begin
                    st = 8'($urandom);
                    pos = TAPE_LAST - 12'($urandom_range(0, 3));
                end
                2: begin
                    st = 8'($urandom);
                    pos = 12'($urandom);
                end
                3: begin
                    st = 8'h00;
                    pos = 12'($urandom_range(0, 3));
                end
                default: begin
                    st = 8'($urandom);
                    pos = TAPE_LAST;
                end
            endcase
            program_register(tmse_pkg::CFG_START_STATE, 32'(st));
            program_register(tmse_pkg::CFG_START_POS, 32'(pos));
            tx_calm = (phase % 3 == 1);
            rx_calm = (phase % 4 == 2);
            queue_program_phase(PHASE_BUDGET);
            wait_drained();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (predicted_results.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      predicted_results.size()));
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // A correct run, including the tape clearing sweep after reset, ends well within this limit.
    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
